// File: rtl/core/minv_pkg.sv
// minv_pkg: shared types for the modular inverse block
// holds the handshake structs between the sequencer and the shared divide unit
// no dependencies

package minv_pkg;

   // command from the sequencer to the divide unit
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   // status from the divide unit back to the sequencer
   typedef struct packed {
      logic done;
   } div_stat_type;

endpackage : minv_pkg

// File: rtl/core/minv_div.sv
// minv_div: shared bit-serial divide unit, one quotient bit per cycle
// also folds the quotient into a running product with a multiplier word (mod 2^WIDTH)
// depends on minv_pkg

module minv_div
   import minv_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  div_ctrl_type     ctrl,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   input  logic [WIDTH-1:0] mult,
   output div_stat_type     stat,
   output logic [WIDTH-1:0] remainder,
   output logic [WIDTH-1:0] product
);

   localparam int CNT_W = $clog2(WIDTH);

   logic             busy_ff,  busy_in;
   logic             done_ff,  done_in;
   logic [CNT_W-1:0] cnt_ff,   cnt_in;
   logic [WIDTH-1:0] quo_ff,   quo_in;
   logic [WIDTH-1:0] rem_ff,   rem_in;
   logic [WIDTH-1:0] acc_ff,   acc_in;

   logic [WIDTH:0]   rem_shift;
   logic [WIDTH:0]   diff;
   logic             qbit;

   // one restoring step: shift in the next dividend bit and try the subtract
   assign rem_shift = {rem_ff, quo_ff[WIDTH-1]};
   assign diff      = rem_shift - {1'b0, divisor};
   assign qbit      = ~diff[WIDTH];

   // step control and datapath next values
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         acc_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WIDTH-2:0], qbit};
         rem_in = qbit ? diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
         // horner form of quotient times multiplier, msb first
         acc_in = {acc_ff[WIDTH-2:0], 1'b0} + (qbit ? mult : '0);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign stat.done = done_ff;
   assign remainder = rem_ff;
   assign product   = acc_ff;

endmodule : minv_div

// File: rtl/core/modular_inverse_ext_euclid_top.sv
// modular_inverse_ext_euclid_top: modular inverse by extended euclid
// each request runs euclid rounds, one per pass of the bit-serial divide unit, then a final
// reduction on the divide unit when the adjusted coefficient is still not below the modulus
// requests: one transaction at a time; a zero modulus skips the divide unit
// reset: synchronous, active high; clears the sequencer and the result valid flag
// depends on minv_pkg and minv_div

module modular_inverse_ext_euclid_top
   import minv_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata, low bit up: value, modulus, zero fill
   input  logic [((2 * WIDTH + 7) / 8) * 8-1:0] req_tdata,
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata, low bit up: inverse_out, gcd_out, zero fill
   output logic [((2 * WIDTH + 7) / 8) * 8-1:0] rsp_tdata,
   // tuser: not_invertible
   output logic                                 rsp_tuser
);

   localparam int DATA_W = ((2 * WIDTH + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_REDUCE,
      ST_FINISH
   } state_type;

   state_type        state_ff,    state_in;
   logic [WIDTH-1:0] rp_ff,       rp_in;
   logic [WIDTH-1:0] rc_ff,       rc_in;
   logic [WIDTH-1:0] cp_ff,       cp_in;
   logic [WIDTH-1:0] cc_ff,       cc_in;
   logic [WIDTH-1:0] n_ff,        n_in;
   logic             start_ff,    start_in;
   logic [WIDTH-1:0] res_inv_ff,  res_inv_in;
   logic [WIDTH-1:0] res_gcd_ff,  res_gcd_in;
   logic             res_bad_ff,  res_bad_in;
   logic             rsp_vld_ff,  rsp_vld_in;
   logic [WIDTH-1:0] rsp_inv_ff,  rsp_inv_in;
   logic [WIDTH-1:0] rsp_gcd_ff,  rsp_gcd_in;
   logic             rsp_bad_ff,  rsp_bad_in;

   logic [WIDTH-1:0] req_value;
   logic [WIDTH-1:0] req_modulus;
   logic [WIDTH-1:0] adj;
   logic [WIDTH-1:0] div_rem;
   logic [WIDTH-1:0] div_prod;
   div_ctrl_type     div_ctrl;
   div_stat_type     div_stat;

   assign req_value   = req_tdata[WIDTH-1:0];
   assign req_modulus = req_tdata[2*WIDTH-1:WIDTH];

   // shared divide unit: rp / rc, product of quotient and cc
   assign div_ctrl.start = start_ff;

   minv_div #(
      .WIDTH (WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (rp_ff),
      .divisor   (rc_ff),
      .mult      (cc_ff),
      .stat      (div_stat),
      .remainder (div_rem),
      .product   (div_prod)
   );

   // negative coefficient brought up by the modulus
   assign adj = cp_ff[WIDTH-1] ? (cp_ff + n_ff) : cp_ff;

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      rp_in      = rp_ff;
      rc_in      = rc_ff;
      cp_in      = cp_ff;
      cc_in      = cc_ff;
      n_in       = n_ff;
      start_in   = 1'b0;
      res_inv_in = res_inv_ff;
      res_gcd_in = res_gcd_ff;
      res_bad_in = res_bad_ff;
      rsp_vld_in = rsp_vld_ff & ~rsp_tready;
      rsp_inv_in = rsp_inv_ff;
      rsp_gcd_in = rsp_gcd_ff;
      rsp_bad_in = rsp_bad_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               n_in = req_modulus;
               if (req_modulus == '0) begin
                  // zero modulus: plain gcd, inverse only for a value of one
                  res_gcd_in = req_value;
                  res_bad_in = (req_value != WIDTH'(1));
                  res_inv_in = (req_value == WIDTH'(1)) ? WIDTH'(1) : '0;
                  state_in   = ST_FINISH;
               end else begin
                  rp_in    = req_value;
                  rc_in    = req_modulus;
                  cp_in    = WIDTH'(1);
                  cc_in    = '0;
                  start_in = 1'b1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // one euclid round per division
            if (div_stat.done) begin
               rp_in = rc_ff;
               rc_in = div_rem;
               cp_in = cc_ff;
               cc_in = cp_ff - div_prod;
               if (div_rem == '0) begin
                  state_in = ST_CHECK;
               end else begin
                  start_in = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            res_gcd_in = rp_ff;
            if (rp_ff != WIDTH'(1)) begin
               res_bad_in = 1'b1;
               res_inv_in = '0;
               state_in   = ST_FINISH;
            end else begin
               res_bad_in = 1'b0;
               if (adj >= n_ff) begin
                  // still out of range: reduce on the divide unit
                  rp_in    = adj;
                  rc_in    = n_ff;
                  start_in = 1'b1;
                  state_in = ST_REDUCE;
               end else begin
                  res_inv_in = adj;
                  state_in   = ST_FINISH;
               end
            end
         end
         ST_REDUCE: begin
            if (div_stat.done) begin
               res_inv_in = div_rem;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // load the output register once it is free
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in = 1'b1;
               rsp_inv_in = res_inv_ff;
               rsp_gcd_in = res_gcd_ff;
               rsp_bad_in = res_bad_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         start_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         start_ff   <= start_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      rp_ff      <= rp_in;
      rc_ff      <= rc_in;
      cp_ff      <= cp_in;
      cc_ff      <= cc_in;
      n_ff       <= n_in;
      res_inv_ff <= res_inv_in;
      res_gcd_ff <= res_gcd_in;
      res_bad_ff <= res_bad_in;
      rsp_inv_ff <= rsp_inv_in;
      rsp_gcd_ff <= rsp_gcd_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = DATA_W'({rsp_gcd_ff, rsp_inv_ff});
   assign rsp_tuser  = rsp_bad_ff;

endmodule : modular_inverse_ext_euclid_top
